// ===== rtl/ftp_pkg.sv =====
// ftp_pkg: shared types and constants for the four-op token pipeline
// no dependencies; used by every module of the block
package ftp_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam int IQ_DEPTH = 16;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

    localparam int WB_DEPTH = 4;
    localparam int WB_CW    = $clog2(WB_DEPTH + 1);

    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        ACT_PRELOAD = 2'd0,
        ACT_ENQUEUE = 2'd1,
        ACT_STEP    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_ST  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            op;
        logic [REG_AW-1:0]  dst;
        logic [REG_AW-1:0]  s1;
        logic [REG_AW-1:0]  s2;
        logic [DATA_W-1:0]  imm;
    } t_instr;

    typedef struct packed {
        t_action            action;
        logic               instr_valid;
        t_instr             instr;
        logic [DATA_W-1:0]  preload_value;
    } t_in_item;

    typedef struct packed {
        logic               valid;
        t_opcode            op;
        logic [REG_AW-1:0]  dst;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
    } t_stage;

    typedef struct packed {
        logic               valid;
        logic [REG_AW-1:0]  dst;
        logic [DATA_W-1:0]  value;
    } t_addr_stage;

    typedef struct packed {
        logic [REG_AW-1:0]  idx;
        logic [DATA_W-1:0]  val;
    } t_wb;

    typedef struct packed {
        logic               reg_write_valid;
        logic [REG_AW-1:0]  reg_write_index;
        logic [DATA_W-1:0]  reg_write_value;
        logic               mem_write_valid;
        logic [DATA_W-1:0]  mem_write_addr;
        logic [DATA_W-1:0]  mem_write_value;
        logic               pipeline_empty;
        logic               queue_full;
    } t_result;

endpackage

// ===== rtl/four_op_token_pipeline.sv =====
// four_op_token_pipeline: top level of the four-op token pipeline
// instantiates ftp_in_reg, ftp_core and ftp_out_reg; depends on ftp_pkg
//
// Each slave transaction preloads a register, enqueues an instruction, or
// advances the ADD/SUB/MUL/ST pipeline by one step, and gives exactly one
// master transaction carrying the register write, the emitted store and the
// status flags. One item is taken per clock cycle unless the master stalls;
// it passes the input register and the result register, with the whole step
// applied between them (its longest path is the 32x32 multiply feeding the
// writeback queue). Both writes are reported; only register writes are kept.
module four_op_token_pipeline (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode, dest_reg, src1_reg, src2_reg, immediate, preload_value, zero pad
    input  logic [ftp_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action, instr_valid
    input  logic [ftp_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // reg_write_index, reg_write_value, mem_write_addr, mem_write_value,
    // pipeline_empty, queue_full, zero pad
    output logic [ftp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // reg_write_valid, mem_write_valid
    output logic [ftp_pkg::OUT_TUSER_W-1:0] m_tuser
);

    ftp_pkg::t_in_item in_item, core_item;
    ftp_pkg::t_result  core_result, out_result;
    logic              core_valid, out_ready, fire;

    always_comb begin
        in_item.action        = ftp_pkg::t_action'(s_tuser[1:0]);
        in_item.instr_valid   = s_tuser[2];
        in_item.instr.op      = ftp_pkg::t_opcode'(s_tdata[1:0]);
        in_item.instr.dst     = s_tdata[5:2];
        in_item.instr.s1      = s_tdata[9:6];
        in_item.instr.s2      = s_tdata[13:10];
        in_item.instr.imm     = s_tdata[45:14];
        in_item.preload_value = s_tdata[77:46];
    end

    assign fire = core_valid && out_ready;

    ftp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .o_item  (core_item),
        .i_take  (fire)
    );

    ftp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (core_item),
        .o_result (core_result)
    );

    ftp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (m_tvalid),
        .o_result (out_result),
        .i_ready  (m_tready)
    );

    assign m_tdata = {2'b00,
                      out_result.queue_full,
                      out_result.pipeline_empty,
                      out_result.mem_write_value,
                      out_result.mem_write_addr,
                      out_result.reg_write_value,
                      out_result.reg_write_index};
    assign m_tuser = {out_result.mem_write_valid, out_result.reg_write_valid};

endmodule

// ===== rtl/ftp_in_reg.sv =====
// ftp_in_reg: input register that holds one accepted transaction
// depends on ftp_pkg
module ftp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ftp_pkg::t_in_item i_item,
    output logic              o_valid,
    output ftp_pkg::t_in_item o_item,
    input  logic              i_take
);

    logic              r_valid;
    ftp_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/ftp_core.sv =====
// ftp_core: register file, instruction queue, pipeline stages and writeback queue
// one item is applied per fire; depends on ftp_pkg
module ftp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ftp_pkg::t_in_item i_item,
    output ftp_pkg::t_result  o_result
);

    localparam int DW = ftp_pkg::DATA_W;

    logic [DW-1:0]                 r_rf [ftp_pkg::REG_COUNT];
    ftp_pkg::t_instr               r_iq [ftp_pkg::IQ_DEPTH];
    logic [ftp_pkg::IQ_AW-1:0]     r_head, n_head;
    logic [ftp_pkg::IQ_CW-1:0]     r_count, n_count;
    ftp_pkg::t_stage               r_issue, n_issue;
    ftp_pkg::t_stage               r_arith, n_arith;
    ftp_pkg::t_stage               r_mul, n_mul;
    ftp_pkg::t_stage               r_store, n_store;
    ftp_pkg::t_addr_stage          r_addr, n_addr;
    ftp_pkg::t_wb                  r_wb [ftp_pkg::WB_DEPTH];
    ftp_pkg::t_wb                  n_wb [ftp_pkg::WB_DEPTH];
    logic [ftp_pkg::WB_CW-1:0]     r_wb_count, n_wb_count;

    logic                          is_step;
    logic                          wb_pop;
    ftp_pkg::t_wb                  wb_head;
    ftp_pkg::t_instr               head_instr;
    logic [DW-1:0]                 rd_a, rd_b, rd_st;
    logic [DW-1:0]                 mul_lo;
    logic [DW-1:0]                 arith_res;
    logic                          push_m, push_a;
    logic                          iq_pop, push_req, iq_full, iq_push;
    logic [ftp_pkg::IQ_AW-1:0]     head1, slot;
    logic [ftp_pkg::IQ_CW-1:0]     count1;
    logic [ftp_pkg::IQ_CW:0]       slot_sum;
    logic [ftp_pkg::WB_CW-1:0]     wb_c1, wb_c2;
    logic                          m_ok, a_ok;
    logic                          rf_we;
    logic [ftp_pkg::REG_AW-1:0]    rf_waddr;
    logic [DW-1:0]                 rf_wdata;

    assign is_step    = (i_item.action == ftp_pkg::ACT_STEP);
    assign wb_pop     = is_step && (r_wb_count != '0);
    assign wb_head    = r_wb[0];
    assign head_instr = r_iq[r_head];

    // register reads see this step's writeback
    assign rd_a  = (wb_pop && wb_head.idx == head_instr.s1) ? wb_head.val : r_rf[head_instr.s1];
    assign rd_b  = (wb_pop && wb_head.idx == head_instr.s2) ? wb_head.val : r_rf[head_instr.s2];
    assign rd_st = (wb_pop && wb_head.idx == r_addr.dst) ? wb_head.val : r_rf[r_addr.dst];

    assign mul_lo    = r_mul.a * r_mul.b;
    assign arith_res = (r_arith.op == ftp_pkg::OP_SUB) ? (r_arith.a - r_arith.b)
                                                       : (r_arith.a + r_arith.b);
    assign push_m    = is_step && r_mul.valid;
    assign push_a    = is_step && r_arith.valid && (r_arith.op != ftp_pkg::OP_MUL);

    // instruction queue
    assign iq_pop   = is_step && (r_count != '0);
    assign head1    = !iq_pop ? r_head
                    : (r_head == ftp_pkg::IQ_AW'(ftp_pkg::IQ_DEPTH - 1)) ? '0
                    : r_head + 1'b1;
    assign count1   = r_count - ftp_pkg::IQ_CW'(iq_pop);
    assign push_req = (i_item.action == ftp_pkg::ACT_ENQUEUE) ||
                      (is_step && i_item.instr_valid);
    assign iq_full  = (count1 == ftp_pkg::IQ_CW'(ftp_pkg::IQ_DEPTH));
    assign iq_push  = push_req && !iq_full;
    assign slot_sum = (ftp_pkg::IQ_CW + 1)'(head1) + (ftp_pkg::IQ_CW + 1)'(count1);
    assign slot     = (slot_sum >= (ftp_pkg::IQ_CW + 1)'(ftp_pkg::IQ_DEPTH))
                    ? ftp_pkg::IQ_AW'(slot_sum - (ftp_pkg::IQ_CW + 1)'(ftp_pkg::IQ_DEPTH))
                    : ftp_pkg::IQ_AW'(slot_sum);
    assign n_head   = head1;
    assign n_count  = count1 + ftp_pkg::IQ_CW'(iq_push);

    // writeback queue: pop front, then multiply result, then add/sub result
    assign wb_c1      = r_wb_count - ftp_pkg::WB_CW'(wb_pop);
    assign m_ok       = push_m && (wb_c1 < ftp_pkg::WB_CW'(ftp_pkg::WB_DEPTH));
    assign wb_c2      = wb_c1 + ftp_pkg::WB_CW'(m_ok);
    assign a_ok       = push_a && (wb_c2 < ftp_pkg::WB_CW'(ftp_pkg::WB_DEPTH));
    assign n_wb_count = wb_c2 + ftp_pkg::WB_CW'(a_ok);

    always_comb begin
        for (int i = 0; i < ftp_pkg::WB_DEPTH; i++) begin
            n_wb[i] = r_wb[i];
        end
        if (wb_pop) begin
            for (int i = 0; i < ftp_pkg::WB_DEPTH - 1; i++) begin
                n_wb[i] = r_wb[i + 1];
            end
        end
        for (int i = 0; i < ftp_pkg::WB_DEPTH; i++) begin
            if (m_ok && wb_c1 == ftp_pkg::WB_CW'(i)) begin
                n_wb[i].idx = r_mul.dst;
                n_wb[i].val = mul_lo;
            end
            if (a_ok && wb_c2 == ftp_pkg::WB_CW'(i)) begin
                n_wb[i].idx = r_arith.dst;
                n_wb[i].val = arith_res;
            end
        end
    end

    // stage movement
    always_comb begin
        n_issue = r_issue;
        n_arith = r_arith;
        n_mul   = r_mul;
        n_store = r_store;
        n_addr  = r_addr;
        if (is_step) begin
            n_addr.valid = r_store.valid;
            n_addr.dst   = r_store.dst;
            n_addr.value = r_store.a + r_store.b;

            n_store       = r_issue;
            n_store.valid = r_issue.valid && (r_issue.op == ftp_pkg::OP_ST);
            n_arith       = r_issue;
            n_arith.valid = r_issue.valid && (r_issue.op != ftp_pkg::OP_ST);

            n_mul       = r_arith;
            n_mul.valid = r_arith.valid && (r_arith.op == ftp_pkg::OP_MUL);

            n_issue.valid = iq_pop;
            n_issue.op    = head_instr.op;
            n_issue.dst   = head_instr.dst;
            n_issue.a     = rd_a;
            n_issue.b     = (head_instr.op == ftp_pkg::OP_ST) ? head_instr.imm : rd_b;
        end
    end

    assign rf_we    = (i_item.action == ftp_pkg::ACT_PRELOAD) || wb_pop;
    assign rf_waddr = wb_pop ? wb_head.idx : i_item.instr.dst;
    assign rf_wdata = wb_pop ? wb_head.val : i_item.preload_value;

    always_comb begin
        o_result.reg_write_valid = wb_pop;
        o_result.reg_write_index = wb_pop ? wb_head.idx : '0;
        o_result.reg_write_value = wb_pop ? wb_head.val : '0;
        o_result.mem_write_valid = is_step && r_addr.valid;
        o_result.mem_write_addr  = (is_step && r_addr.valid) ? r_addr.value : '0;
        o_result.mem_write_value = (is_step && r_addr.valid) ? rd_st : '0;
        o_result.pipeline_empty  = (n_count == '0) && !n_issue.valid && !n_arith.valid &&
                                   !n_mul.valid && !n_store.valid && !n_addr.valid &&
                                   (n_wb_count == '0);
        o_result.queue_full      = push_req && iq_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_wb_count    <= '0;
            r_issue.valid <= 1'b0;
            r_arith.valid <= 1'b0;
            r_mul.valid   <= 1'b0;
            r_store.valid <= 1'b0;
            r_addr.valid  <= 1'b0;
            for (int i = 0; i < ftp_pkg::REG_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else if (i_fire) begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_wb_count <= n_wb_count;
            r_issue    <= n_issue;
            r_arith    <= n_arith;
            r_mul      <= n_mul;
            r_store    <= n_store;
            r_addr     <= n_addr;
            if (rf_we) begin
                r_rf[rf_waddr] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int i = 0; i < ftp_pkg::WB_DEPTH; i++) begin
                r_wb[i] <= n_wb[i];
            end
            if (iq_push) begin
                r_iq[slot] <= i_item.instr;
            end
        end
    end

endmodule

// ===== rtl/ftp_out_reg.sv =====
// ftp_out_reg: result register toward the master side
// depends on ftp_pkg
module ftp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ftp_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    output ftp_pkg::t_result o_result,
    input  logic             i_ready
);

    logic             r_valid;
    ftp_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/ftp_checker.sv =====
// ftp_checker: port-level assertions for four_op_token_pipeline
// bound to the top level; depends on ftp_pkg
module ftp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [ftp_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input logic [ftp_pkg::OUT_TUSER_W-1:0] i_m_tuser
);

    // no register write means zero index and value
    a_reg_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser[0]) |-> (i_m_tdata[35:0] == '0))
        else $error("register write fields set without a register write");

    // no store means zero address and value
    a_mem_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser[1]) |-> (i_m_tdata[99:36] == '0))
        else $error("store fields set without a store");

    // a dropped instruction means the queue is full, so not empty
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[101]) |-> !i_m_tdata[100])
        else $error("queue full reported with an empty pipeline");

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("master transaction changed while stalled");

endmodule

bind four_op_token_pipeline ftp_checker u_ftp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: checks four_op_token_pipeline against its own model of the pipeline step
// drives random preload, enqueue and step transactions with random stalls on both sides
// depends on ftp_pkg and the four_op_token_pipeline rtl
module testbench;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 920;
    localparam int         LONG_HOLD      = 300;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;

    class step_scoreboard;
        logic [ftp_pkg::DATA_W-1:0] regs [ftp_pkg::REG_COUNT];
        ftp_pkg::t_instr            iq [ftp_pkg::IQ_DEPTH];
        int                         iq_head;
        int                         iq_count;
        ftp_pkg::t_stage            issue_st;
        ftp_pkg::t_stage            arith_st;
        ftp_pkg::t_stage            mul_st;
        ftp_pkg::t_stage            store_st;
        ftp_pkg::t_addr_stage       addr_st;
        ftp_pkg::t_wb               wbq [ftp_pkg::WB_DEPTH];
        int                         wb_count;
        ftp_pkg::t_result           expected_steps [$];
        int                         errors;
        int                         n_items;
        int                         n_reg_writes;
        int                         n_stores;
        int                         n_drops;

        function new();
            foreach (regs[i]) regs[i] = '0;
            iq_head  = 0;
            iq_count = 0;
            issue_st = '0;
            arith_st = '0;
            mul_st   = '0;
            store_st = '0;
            addr_st  = '0;
            wb_count = 0;
            errors   = 0;
            n_items  = 0;
            n_reg_writes = 0;
            n_stores = 0;
            n_drops  = 0;
        endfunction

        function bit push_instr(ftp_pkg::t_instr ins);
            if (iq_count >= ftp_pkg::IQ_DEPTH) return 1'b0;
            iq[(iq_head + iq_count) % ftp_pkg::IQ_DEPTH] = ins;
            iq_count++;
            return 1'b1;
        endfunction

        function void push_writeback(logic [ftp_pkg::REG_AW-1:0] idx,
                                     logic [ftp_pkg::DATA_W-1:0] val);
            if (wb_count >= ftp_pkg::WB_DEPTH) return;
            wbq[wb_count].idx = idx;
            wbq[wb_count].val = val;
            wb_count++;
        endfunction

        function bit is_empty();
            return iq_count == 0 && !issue_st.valid && !arith_st.valid && !mul_st.valid &&
                   !store_st.valid && !addr_st.valid && wb_count == 0;
        endfunction

        function void advance(inout ftp_pkg::t_result r);
            ftp_pkg::t_instr ins;
            if (wb_count > 0) begin
                regs[wbq[0].idx] = wbq[0].val;
                r.reg_write_valid = 1'b1;
                r.reg_write_index = wbq[0].idx;
                r.reg_write_value = wbq[0].val;
                for (int i = 0; i < ftp_pkg::WB_DEPTH - 1; i++) wbq[i] = wbq[i+1];
                wb_count--;
            end
            if (addr_st.valid) begin
                r.mem_write_valid = 1'b1;
                r.mem_write_addr  = addr_st.value;
                r.mem_write_value = regs[addr_st.dst];
                addr_st.valid = 1'b0;
            end
            if (store_st.valid) begin
                addr_st.valid = 1'b1;
                addr_st.dst   = store_st.dst;
                addr_st.value = store_st.a + store_st.b;
                store_st.valid = 1'b0;
            end
            if (mul_st.valid) begin
                push_writeback(mul_st.dst, mul_st.a * mul_st.b);
                mul_st.valid = 1'b0;
            end
            if (arith_st.valid) begin
                if (arith_st.op == ftp_pkg::OP_MUL) mul_st = arith_st;
                else if (arith_st.op == ftp_pkg::OP_SUB)
                    push_writeback(arith_st.dst, arith_st.a - arith_st.b);
                else
                    push_writeback(arith_st.dst, arith_st.a + arith_st.b);
                arith_st.valid = 1'b0;
            end
            if (issue_st.valid) begin
                if (issue_st.op == ftp_pkg::OP_ST) store_st = issue_st;
                else arith_st = issue_st;
                issue_st.valid = 1'b0;
            end
            if (iq_count > 0) begin
                ins = iq[iq_head];
                iq_head = (iq_head + 1) % ftp_pkg::IQ_DEPTH;
                iq_count--;
                issue_st.valid = 1'b1;
                issue_st.op    = ins.op;
                issue_st.dst   = ins.dst;
                issue_st.a     = regs[ins.s1];
                issue_st.b     = (ins.op == ftp_pkg::OP_ST) ? ins.imm : regs[ins.s2];
            end
        endfunction

        // accepted slave transaction
        function void note_item(logic [ftp_pkg::IN_TDATA_W-1:0] d,
                                logic [ftp_pkg::IN_TUSER_W-1:0] u);
            ftp_pkg::t_result r;
            ftp_pkg::t_instr  ins;
            logic             dropped;
            r = '0;
            dropped = 1'b0;
            ins.op  = ftp_pkg::t_opcode'(d[1:0]);
            ins.dst = d[5:2];
            ins.s1  = d[9:6];
            ins.s2  = d[13:10];
            ins.imm = d[45:14];
            unique case (u[1:0])
                ftp_pkg::ACT_PRELOAD: regs[ins.dst] = d[77:46];
                ftp_pkg::ACT_ENQUEUE: dropped = !push_instr(ins);
                ftp_pkg::ACT_STEP: begin
                    advance(r);
                    if (u[2]) dropped = !push_instr(ins);
                end
                default: ;
            endcase
            r.pipeline_empty = is_empty();
            r.queue_full     = dropped;
            n_items++;
            n_reg_writes += int'(r.reg_write_valid);
            n_stores     += int'(r.mem_write_valid);
            n_drops      += int'(dropped);
            expected_steps.push_back(r);
        endfunction

        function void compare(string name, logic [ftp_pkg::DATA_W-1:0] exp,
                              logic [ftp_pkg::DATA_W-1:0] act);
            if (act !== exp) begin
                $display("%0t: mismatch %s expected %h actual %h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // accepted master transaction
        function void check_step(logic [ftp_pkg::OUT_TDATA_W-1:0] d,
                                 logic [ftp_pkg::OUT_TUSER_W-1:0] u);
            ftp_pkg::t_result e;
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result tdata %h tuser %h", $time, d, u);
                errors++;
                return;
            end
            e = expected_steps.pop_front();
            compare("reg_write_valid", ftp_pkg::DATA_W'(e.reg_write_valid),
                    ftp_pkg::DATA_W'(u[0]));
            compare("mem_write_valid", ftp_pkg::DATA_W'(e.mem_write_valid),
                    ftp_pkg::DATA_W'(u[1]));
            compare("reg_write_index", ftp_pkg::DATA_W'(e.reg_write_index),
                    ftp_pkg::DATA_W'(d[3:0]));
            compare("reg_write_value", e.reg_write_value, d[35:4]);
            compare("mem_write_addr", e.mem_write_addr, d[67:36]);
            compare("mem_write_value", e.mem_write_value, d[99:68]);
            compare("pipeline_empty", ftp_pkg::DATA_W'(e.pipeline_empty),
                    ftp_pkg::DATA_W'(d[100]));
            compare("queue_full", ftp_pkg::DATA_W'(e.queue_full),
                    ftp_pkg::DATA_W'(d[101]));
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction
    endclass

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ftp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [ftp_pkg::IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ftp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [ftp_pkg::OUT_TUSER_W-1:0] m_tuser;

    step_scoreboard sb = new();
    bit             tx_idle = 1'b1;
    int             idle_cycles = 0;

    four_op_token_pipeline i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_step(m_tdata, m_tuser);
        if (i_rst_n && s_tvalid && s_tready) sb.note_item(s_tdata, s_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results pending", $time, sb.pending());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver, with one long hold-off so the block backs up
    initial begin
        int  stall;
        int  n_rx;
        bit  rx_idle;
        n_rx = 0;
        rx_idle = 1'b1;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (n_rx % 50 == 0) rx_idle = ($urandom_range(0, 3) != 0);
            if (n_rx == LONG_HOLD) stall = LONG_HOLD;
            else stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            n_rx++;
            @(negedge i_clk);
        end
    end

    task automatic send(input logic [1:0] act, input logic iv, input logic [1:0] op,
                        input logic [3:0] dst, input logic [3:0] s1, input logic [3:0] s2,
                        input logic [31:0] imm, input logic [31:0] pv);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= {2'b00, pv, imm, s2, s1, dst, op};
        s_tuser  <= {iv, act};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input logic [1:0] act, input logic iv);
        send(act, iv, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), pick_value(),
             pick_value());
    endtask

    initial begin
        int n_sent;
        int len;
        int mode;
        int pick;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, every opcode, hazards, drops of action 3, empty step
        send(ftp_pkg::ACT_PRELOAD, 1'b1, ftp_pkg::OP_ST, 4'd1, 4'd0, 4'd0, 32'h0,
             32'h7fff_ffff);
        send(ftp_pkg::ACT_PRELOAD, 1'b0, ftp_pkg::OP_ADD, 4'd2, 4'd15, 4'd15, 32'hffff_ffff,
             32'h8000_0000);
        send(ftp_pkg::ACT_PRELOAD, 1'b0, ftp_pkg::OP_MUL, 4'd3, 4'd0, 4'd0, 32'h0,
             32'hffff_ffff);
        send(ftp_pkg::ACT_PRELOAD, 1'b0, ftp_pkg::OP_SUB, 4'd15, 4'd0, 4'd0, 32'h0, 32'h0);
        send(ftp_pkg::ACT_ENQUEUE, 1'b1, ftp_pkg::OP_ADD, 4'd4, 4'd1, 4'd2, 32'h0,
             32'hffff_ffff);
        send(ftp_pkg::ACT_ENQUEUE, 1'b0, ftp_pkg::OP_SUB, 4'd5, 4'd2, 4'd1, 32'h0, 32'h0);
        send(ftp_pkg::ACT_ENQUEUE, 1'b0, ftp_pkg::OP_MUL, 4'd6, 4'd1, 4'd3, 32'h0, 32'h0);
        send(ftp_pkg::ACT_ENQUEUE, 1'b0, ftp_pkg::OP_ST, 4'd3, 4'd2, 4'd0, 32'h8000_0000,
             32'h0);
        send(ftp_pkg::ACT_ENQUEUE, 1'b0, ftp_pkg::OP_ST, 4'd1, 4'd1, 4'd0, 32'h7fff_ffff,
             32'h0);
        send(ACT_UNUSED, 1'b1, ftp_pkg::OP_ST, 4'd15, 4'd15, 4'd15, 32'hffff_ffff,
             32'hffff_ffff);
        send(ftp_pkg::ACT_STEP, 1'b1, ftp_pkg::OP_MUL, 4'd7, 4'd2, 4'd2, 32'h0, 32'h0);
        send(ftp_pkg::ACT_STEP, 1'b0, ftp_pkg::OP_ADD, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0);
        send(ftp_pkg::ACT_PRELOAD, 1'b0, ftp_pkg::OP_ADD, 4'd1, 4'd0, 4'd0, 32'h0, 32'h0);
        send(ftp_pkg::ACT_STEP, 1'b1, ftp_pkg::OP_ADD, 4'd8, 4'd4, 4'd6, 32'h0, 32'h0);
        send(ftp_pkg::ACT_STEP, 1'b1, ftp_pkg::OP_ST, 4'd8, 4'd4, 4'd0, 32'h0000_0010,
             32'h0);
        repeat (7) send(ftp_pkg::ACT_STEP, 1'b0, ftp_pkg::OP_ADD, 4'd0, 4'd0, 4'd0, 32'h0,
                        32'h0);
        send(ftp_pkg::ACT_STEP, 1'b1, ftp_pkg::OP_ST, 4'd15, 4'd0, 4'd0, 32'hffff_ffff,
             32'h0);
        repeat (3) send(ftp_pkg::ACT_STEP, 1'b0, ftp_pkg::OP_SUB, 4'd0, 4'd0, 4'd0, 32'h0,
                        32'h0);

        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                // burst that can overflow the instruction queue
                len = $urandom_range(14, 20);
                repeat (len) send_random(ftp_pkg::ACT_ENQUEUE, 1'($urandom_range(0, 1)));
            end else if (mode == 2) begin
                len = $urandom_range(6, 16);
                repeat (len) send_random(ftp_pkg::ACT_STEP, 1'b0);
            end else begin
                len = $urandom_range(10, 40);
                repeat (len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        send_random(ftp_pkg::ACT_PRELOAD, 1'($urandom_range(0, 1)));
                    else if (pick < 35)
                        send_random(ftp_pkg::ACT_ENQUEUE, 1'($urandom_range(0, 1)));
                    else if (pick < 96)
                        send_random(ftp_pkg::ACT_STEP, $urandom_range(0, 3) != 0);
                    else
                        send_random(ACT_UNUSED, 1'($urandom_range(0, 1)));
                end
            end
            n_sent += len;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("covered %0d transactions: %0d register writes, %0d stores, %0d dropped",
                 sb.n_items, sb.n_reg_writes, sb.n_stores, sb.n_drops);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
